/* hdl/olr_pkg.sv */
// Package for the overwrite-oldest log ring.
// Holds sizes, character codes, operation codes and the stage record type.
// No dependencies.
`default_nettype none
package olr_pkg;

	localparam int DEPTH_LOG2 = 14;
	localparam int ADDR_W     = DEPTH_LOG2;
	localparam int CNT_W      = DEPTH_LOG2 + 1;
	localparam int RING_SIZE  = 1 << DEPTH_LOG2;
	localparam int BYTE_W     = 8;
	localparam int DROP_W     = 32;
	localparam int FILL_W     = 15;

	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

	typedef enum logic {
		FUNC_APPEND = 1'b0,
		FUNC_DRAIN  = 1'b1
	} olr_func_t;

	typedef struct packed {
		logic              hit;
		logic [BYTE_W-1:0] data;
		logic [DROP_W-1:0] drop;
		logic [CNT_W-1:0]  fill;
	} olr_stage_t;

	function automatic logic [FILL_W-1:0] fill_out(input logic [CNT_W-1:0] v);
		return FILL_W'(v);
	endfunction

endpackage
`default_nettype wire

/* hdl/olr_if.sv */
// Channel interfaces for the log ring: command items in, result items out.
// Depends on olr_pkg for field widths.
`default_nettype none
interface olr_cmd_if;
	import olr_pkg::*;
	logic              valid;
	logic              ready;
	logic              func;
	logic [BYTE_W-1:0] in_byte;
	modport source (output valid, func, in_byte, input ready);
	modport sink (input valid, func, in_byte, output ready);
endinterface

interface olr_res_if;
	import olr_pkg::*;
	logic              valid;
	logic              ready;
	logic              out_valid;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;
	logic [DROP_W-1:0] dropped_total;
	logic [FILL_W-1:0] fill_level;
	modport source (output valid, out_valid, out_byte, last_of_run, dropped_total,
		fill_level, input ready);
	modport sink (input valid, out_valid, out_byte, last_of_run, dropped_total,
		fill_level, output ready);
endinterface
`default_nettype wire

/* hdl/olr_ctrl.sv */
// Ring control: byte store, write and read counts, drop counter, stage-1 register.
// Depends on olr_pkg and olr_cmd_if.
`default_nettype none
module olr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	olr_cmd_if.sink             cmd,
	input  wire logic           pop,
	output logic                stage_valid,
	output olr_pkg::olr_stage_t stage
);
	import olr_pkg::*;

	logic [BYTE_W-1:0] ring_mem [RING_SIZE];

	logic [CNT_W-1:0]  wr_cnt_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic [DROP_W-1:0] drop_q;
	logic [CNT_W-1:0]  fill_cur;
	logic              full;
	logic              empty;
	logic              accept;
	logic              do_write;
	logic              do_read;
	logic [CNT_W-1:0]  wr_cnt_nxt;
	logic [CNT_W-1:0]  rd_cnt_nxt;
	logic [DROP_W-1:0] drop_nxt;

	logic              valid_s1;
	logic              hit_s1;
	logic [BYTE_W-1:0] rd_data_s1;
	logic [DROP_W-1:0] drop_s1;
	logic [CNT_W-1:0]  fill_s1;

	assign fill_cur  = wr_cnt_q - rd_cnt_q;
	assign full      = fill_cur[ADDR_W];
	assign empty     = (fill_cur == '0);
	assign cmd.ready = !valid_s1 || pop;
	assign accept    = cmd.valid && cmd.ready;
	assign do_write  = accept && (cmd.func == FUNC_APPEND) && (cmd.in_byte != CH_NUL);
	assign do_read   = accept && (cmd.func == FUNC_DRAIN) && !empty;

	always_comb begin
		wr_cnt_nxt = wr_cnt_q;
		rd_cnt_nxt = rd_cnt_q;
		drop_nxt   = drop_q;
		if (do_write) begin
			wr_cnt_nxt = wr_cnt_q + CNT_W'(1);
			if (full) begin
				rd_cnt_nxt = rd_cnt_q + CNT_W'(1);
				drop_nxt   = drop_q + DROP_W'(1);
			end
		end
		if (do_read) begin
			rd_cnt_nxt = rd_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			ring_mem[wr_cnt_q[ADDR_W-1:0]] <= cmd.in_byte;
		end
		if (do_read) begin
			rd_data_s1 <= ring_mem[rd_cnt_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q <= '0;
			rd_cnt_q <= '0;
			drop_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			wr_cnt_q <= wr_cnt_nxt;
			rd_cnt_q <= rd_cnt_nxt;
			drop_q   <= drop_nxt;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (pop) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1  <= do_read;
			drop_s1 <= drop_nxt;
			fill_s1 <= wr_cnt_nxt - rd_cnt_nxt;
		end
	end

	assign stage_valid = valid_s1;
	assign stage.hit   = hit_s1;
	assign stage.data  = rd_data_s1;
	assign stage.drop  = drop_s1;
	assign stage.fill  = fill_s1;

endmodule
`default_nettype wire

/* hdl/olr_out.sv */
// Result register: expands a drained line feed into carriage return then line feed.
// Depends on olr_pkg and olr_res_if.
`default_nettype none
module olr_out (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                stage_valid,
	input  wire olr_pkg::olr_stage_t stage,
	output logic                     pop,
	olr_res_if.source                res
);
	import olr_pkg::*;

	logic              res_valid_q;
	logic              cr_sent_q;
	logic              hit_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic [DROP_W-1:0] drop_q;
	logic [FILL_W-1:0] fill_q;
	logic              is_lf;
	logic              send_cr;
	logic              load;

	assign is_lf   = stage.hit && (stage.data == CH_LF);
	assign send_cr = is_lf && !cr_sent_q;
	assign load    = stage_valid && (!res_valid_q || res.ready);
	assign pop     = load && !send_cr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			cr_sent_q   <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				cr_sent_q   <= send_cr;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hit_q  <= stage.hit;
			byte_q <= !stage.hit ? CH_NUL : (send_cr ? CH_CR : stage.data);
			last_q <= !send_cr;
			drop_q <= stage.drop;
			fill_q <= fill_out(stage.fill);
		end
	end

	assign res.valid         = res_valid_q;
	assign res.out_valid     = hit_q;
	assign res.out_byte      = byte_q;
	assign res.last_of_run   = last_q;
	assign res.dropped_total = drop_q;
	assign res.fill_level    = fill_q;

endmodule
`default_nettype wire

/* hdl/overwrite_oldest_log_ring.sv */
// Top level of the overwrite-oldest log ring: control stage and result register.
// Depends on olr_pkg, olr_if, olr_ctrl and olr_out.
//
// A byte ring of 2^DEPTH_LOG2 entries for console text. Append items (func 0) store
// a nonzero byte, discarding the oldest byte and counting a drop when full; drain
// items (func 1) return the oldest byte, a line feed coming out as carriage return
// then line feed. Every item gives one result (two for a drained line feed), which
// reports the drop count and fill level after the item. One item is accepted per
// cycle while the result side does not stall; a result goes from the stage-1 register,
// which takes the store's registered read port, into the result register.
// A drained line feed holds the result register for its carriage return and then its
// line feed, so the next item waits behind it. The store has no reset or clearing pass.
`default_nettype none
module overwrite_oldest_log_ring (
	input  wire logic clk,
	input  wire logic arst_n,
	olr_cmd_if.sink   cmd,
	olr_res_if.source res
);
	import olr_pkg::*;

	logic       stage_valid;
	olr_stage_t stage;
	logic       pop;

	olr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pop         (pop),
		.stage_valid (stage_valid),
		.stage       (stage)
	);

	olr_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage_valid (stage_valid),
		.stage       (stage),
		.pop         (pop),
		.res         (res)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid |-> (stage.fill <= CNT_W'(RING_SIZE)))
		else $error("fill level beyond ring size");

	a_first_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.last_of_run) |-> (res.out_valid && res.out_byte == CH_CR))
		else $error("non-final result is not a carriage return");

	a_lf_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.last_of_run) |=>
		(res.valid && res.out_valid && res.last_of_run && res.out_byte == CH_LF))
		else $error("carriage return not followed by line feed");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.out_valid) |-> (res.last_of_run && res.out_byte == CH_NUL))
		else $error("result without byte is malformed");

endmodule
`default_nettype wire

/* test/tb_overwrite_oldest_log_ring.sv */
// Testbench for overwrite_oldest_log_ring: a directed table, then random append and drain
// items under several idling mixes, checked against an in-bench ring predictor.
// Depends on olr_pkg, olr_if and the RTL of the log ring.
`default_nettype none
module tb_overwrite_oldest_log_ring;
	import olr_pkg::*;

	localparam int LONG_HOLD   = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int N_DIR       = 25;
	localparam int N_BURST     = 50;

	typedef struct packed {
		logic              out_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
		logic [DROP_W-1:0] dropped_total;
		logic [FILL_W-1:0] fill_level;
	} log_out_t;

	typedef struct packed {
		olr_func_t         func;
		logic [BYTE_W-1:0] in_byte;
		logic              typed;
		log_out_t          want;
	} dir_row_t;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{FUNC_DRAIN,  CH_NUL, 1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd0}},
		'{FUNC_APPEND, 8'hFF,  1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd1}},
		'{FUNC_APPEND, CH_NUL, 1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd1}},
		'{FUNC_APPEND, CH_LF,  1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd2}},
		'{FUNC_APPEND, 8'h01,  1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd3}},
		'{FUNC_APPEND, 8'h80,  1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd4}},
		'{FUNC_APPEND, 8'h7F,  1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd5}},
		'{FUNC_DRAIN,  CH_NUL, 1'b1, '{1'b1, 8'hFF,  1'b1, 32'd0, 15'd4}},
		'{FUNC_DRAIN,  CH_NUL, 1'b0, '0},
		'{FUNC_DRAIN,  8'hFF,  1'b1, '{1'b1, 8'h01,  1'b1, 32'd0, 15'd2}},
		'{FUNC_DRAIN,  CH_NUL, 1'b1, '{1'b1, 8'h80,  1'b1, 32'd0, 15'd1}},
		'{FUNC_DRAIN,  CH_NUL, 1'b1, '{1'b1, 8'h7F,  1'b1, 32'd0, 15'd0}},
		'{FUNC_DRAIN,  CH_NUL, 1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd0}},
		'{FUNC_APPEND, CH_CR,  1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd1}},
		'{FUNC_APPEND, CH_LF,  1'b0, '0},
		'{FUNC_APPEND, CH_LF,  1'b0, '0},
		'{FUNC_DRAIN,  CH_NUL, 1'b1, '{1'b1, CH_CR,  1'b1, 32'd0, 15'd2}},
		'{FUNC_DRAIN,  CH_NUL, 1'b0, '0},
		'{FUNC_DRAIN,  CH_NUL, 1'b0, '0},
		'{FUNC_APPEND, CH_NUL, 1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd0}},
		'{FUNC_DRAIN,  CH_NUL, 1'b1, '{1'b0, CH_NUL, 1'b1, 32'd0, 15'd0}},
		'{FUNC_APPEND, 8'hAA,  1'b0, '0},
		'{FUNC_APPEND, 8'h55,  1'b0, '0},
		'{FUNC_DRAIN,  8'hFF,  1'b0, '0},
		'{FUNC_DRAIN,  CH_LF,  1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	olr_cmd_if cmd_ch ();
	olr_res_if res_ch ();

	overwrite_oldest_log_ring u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [BYTE_W-1:0] ring_img [RING_SIZE];
	logic [CNT_W-1:0]  wr_cnt   = '0;
	logic [CNT_W-1:0]  rd_cnt   = '0;
	logic [DROP_W-1:0] drop_cnt = '0;
	log_out_t          pending_out [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asks      = 0;
	int hold_done      = 0;
	int hold_left      = 0;
	int quiet_cyc      = 0;
	int mismatch_cnt   = 0;

	task automatic ring_advance(input olr_func_t f, input logic [BYTE_W-1:0] b,
		input logic typed, input log_out_t want);
		logic [CNT_W-1:0] held;
		log_out_t r;
		held = wr_cnt - rd_cnt;
		r = '0;
		r.last_of_run = 1'b1;
		if (f == FUNC_APPEND) begin
			if (b != CH_NUL) begin
				if (held >= CNT_W'(RING_SIZE)) begin
					rd_cnt++;
					drop_cnt++;
				end
				ring_img[wr_cnt[ADDR_W-1:0]] = b;
				wr_cnt++;
			end
		end else if (held != '0) begin
			r.out_valid = 1'b1;
			r.out_byte = ring_img[rd_cnt[ADDR_W-1:0]];
			rd_cnt++;
		end
		r.dropped_total = drop_cnt;
		r.fill_level = FILL_W'(wr_cnt - rd_cnt);
		if (typed) begin
			pending_out.push_back(want);
		end else if (r.out_valid && r.out_byte == CH_LF) begin
			r.out_byte = CH_CR;
			r.last_of_run = 1'b0;
			pending_out.push_back(r);
			r.out_byte = CH_LF;
			r.last_of_run = 1'b1;
			pending_out.push_back(r);
		end else begin
			pending_out.push_back(r);
		end
	endtask

	task automatic set_idling(input idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 79;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 79;
			end
			default: begin
				send_idle_pct = 27;
				recv_stall_pct = 27;
			end
		endcase
	endtask

	// enter and leave at a falling edge; valid stays high for a back-to-back item
	task automatic send_item(input olr_func_t f, input logic [BYTE_W-1:0] b,
		input logic typed, input log_out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= f;
		cmd_ch.in_byte <= b;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		ring_advance(f, b, typed, want);
		@(negedge clk);
	endtask

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(9))
			0: return CH_LF;
			1: return CH_NUL;
			2: return CH_CR;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	task automatic send_random(input int drain_pct);
		if ($urandom_range(99) < drain_pct)
			send_item(FUNC_DRAIN, pick_byte(), 1'b0, '0);
		else
			send_item(FUNC_APPEND, pick_byte(), 1'b0, '0);
	endtask

	task automatic check_field(input string name, input logic [DROP_W-1:0] want,
		input logic [DROP_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(negedge clk) begin
		if (hold_asks != hold_done) begin
			hold_done = hold_asks;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		log_out_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_out.size() == 0) begin
				$error("unexpected result: out_valid %0b out_byte 0x%0h last_of_run %0b",
					res_ch.out_valid, res_ch.out_byte, res_ch.last_of_run);
				mismatch_cnt++;
			end else begin
				want = pending_out.pop_front();
				check_field("out_valid", DROP_W'(want.out_valid),
					DROP_W'(res_ch.out_valid));
				check_field("out_byte", DROP_W'(want.out_byte),
					DROP_W'(res_ch.out_byte));
				check_field("last_of_run", DROP_W'(want.last_of_run),
					DROP_W'(res_ch.last_of_run));
				check_field("dropped_total", want.dropped_total, res_ch.dropped_total);
				check_field("fill_level", DROP_W'(want.fill_level),
					DROP_W'(res_ch.fill_level));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cyc <= 0;
		end else if (quiet_cyc >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cyc <= quiet_cyc + 1;
		end
	end

	initial begin
		int i;
		int k;
		int wait_cyc;
		logic [BYTE_W-1:0] b;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_APPEND;
		cmd_ch.in_byte = CH_NUL;
		res_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < N_DIR; i++)
			send_item(DIR_ROWS[i].func, DIR_ROWS[i].in_byte, DIR_ROWS[i].typed,
				DIR_ROWS[i].want);

		for (i = 0; i < 4; i++) begin
			set_idling(idle_mode_t'(i));
			if (i == 0)
				hold_asks++;
			for (k = 0; k < 200; k++)
				send_random((k < 100) ? 40 : 65);
			if (i == 1) begin
				cmd_ch.valid <= 1'b0;
				while (pending_out.size() != 0)
					@(negedge clk);
			end
		end

		// burst of nonzero appends with no drains to raise the fill level
		set_idling(IDLE_NONE);
		for (k = 0; k < N_BURST; k++) begin
			b = pick_byte();
			if (b == CH_NUL)
				b = CH_LF;
			send_item(FUNC_APPEND, b, 1'b0, '0);
		end

		hold_asks++;
		for (k = 0; k < 300; k++) begin
			if (k % 75 == 0)
				set_idling(idle_mode_t'(k / 75));
			send_random(45);
		end
		cmd_ch.valid <= 1'b0;

		wait_cyc = 0;
		while (pending_out.size() != 0 && wait_cyc < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (8) @(posedge clk);
		if (pending_out.size() != 0) begin
			$error("%0d expected results never arrived", pending_out.size());
			mismatch_cnt++;
		end
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
hdl/olr_pkg.sv
hdl/olr_if.sv
hdl/olr_ctrl.sv
hdl/olr_out.sv
hdl/overwrite_oldest_log_ring.sv
test/tb_overwrite_oldest_log_ring.sv
